/* rtl/rcpa_pkg.sv */
// Shared constants, codes and control structs of the reference-counted page allocator.
// No dependencies; imported by rcpa_ctrl, rcpa_dp and refcounted_page_allocator.
package rcpa_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_PAGES_DEF  = 32768;
  localparam int REF_BITS_DEF   = 8;
  localparam int PAGE_SHIFT_DEF = 12;

  // Fixed field widths
  localparam int ADDR_BITS = 32;
  localparam int BASE_W    = 20;
  localparam int LIMIT_W   = 21;
  localparam int OPC_W     = 3;
  localparam int STAT_W    = 3;
  localparam int CNT_OUT_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(32768);

  // Opcodes
  localparam logic [OPC_W-1:0] OP_INIT   = 3'd0;
  localparam logic [OPC_W-1:0] OP_ALLOC  = 3'd1;
  localparam logic [OPC_W-1:0] OP_FREE   = 3'd2;
  localparam logic [OPC_W-1:0] OP_ADDREF = 3'd3;
  localparam logic [OPC_W-1:0] OP_CLONE  = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_OOM      = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADADDR  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTALLOC = 3'd3;
  localparam logic [STAT_W-1:0] ST_SAT      = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic load_in;     // capture the accepted transaction
    logic decode;      // decode address, read both memories
    logic init_calc;   // work out the clamped page count
    logic init_start;  // latch active range, reset fill counter
    logic fill_step;   // write one page of the init sweep
    logic init_done;   // finish init, publish result
    logic exec;        // commit alloc/free/add_ref/clone step
    logic clone_fin;   // second write of a clone that took a new page
  } rcpa_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_init;
    logic clone_split;
    logic fill_done;
    logic out_free;
  } rcpa_stat_t;

endpackage

/* rtl/rcpa_ctrl.sv */
// Sequencing state machine of the page allocator.
// Depends on rcpa_pkg; drives commands into rcpa_dp.
module rcpa_ctrl
  import rcpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  rcpa_stat_t st,
  output rcpa_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DEC    = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_CLONE  = 7'b0001000,
    S_INIT_A = 7'b0010000,
    S_INIT_B = 7'b0100000,
    S_FILL   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        state_nxt  = st.is_init ? S_INIT_A : S_EXEC;
      end
      S_EXEC: begin
        // a clone that takes a new page needs a second count write first
        if (st.clone_split) begin
          cmd.exec  = 1'b1;
          state_nxt = S_CLONE;
        end else if (st.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CLONE: begin
        if (st.out_free) begin
          cmd.clone_fin = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_INIT_A: begin
        cmd.init_calc = 1'b1;
        state_nxt     = S_INIT_B;
      end
      S_INIT_B: begin
        cmd.init_start = 1'b1;
        state_nxt      = S_FILL;
      end
      S_FILL: begin
        if (!st.fill_done) begin
          cmd.fill_step = 1'b1;
        end else if (st.out_free) begin
          cmd.init_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/rcpa_dp.sv */
// Datapath of the page allocator: config registers, free stack and count memories,
// address decode and the result register. Depends on rcpa_pkg; driven by rcpa_ctrl.
module rcpa_dp
  import rcpa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int REF_BITS   = REF_BITS_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rcpa_cmd_t             cmd,
  output rcpa_stat_t            st,
  input  logic [OPC_W-1:0]      in_opcode,
  input  logic [ADDR_BITS-1:0]  in_page_addr,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_W-1:0]     out_status,
  output logic [ADDR_BITS-1:0]  out_result_addr,
  output logic                  out_copy_needed,
  output logic                  out_page_freed,
  output logic [CNT_OUT_W-1:0]  out_ref_count
);

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam int PG_W  = ADDR_BITS - PAGE_SHIFT;
  localparam int CW    = ((PG_W > LIMIT_W) ? PG_W : LIMIT_W) + 1;
  localparam int SUM_W = BASE_W + 1;
  localparam logic [CW-1:0]       CAP     = CW'(1) << PG_W;
  localparam logic [CW-1:0]       MAXP_CW = CW'(MAX_PAGES);
  localparam logic [CNT_W-1:0]    MAXP    = CNT_W'(MAX_PAGES);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  // Memories
  logic [IDX_W-1:0]    stk_mem [MAX_PAGES];
  logic [REF_BITS-1:0] ref_mem [MAX_PAGES];
  logic [IDX_W-1:0]    stk_q;
  logic [REF_BITS-1:0] ref_q;

  // Configuration and active range
  logic [BASE_W-1:0]  base_cfg_r;
  logic [LIMIT_W-1:0] limit_cfg_r;
  logic [BASE_W-1:0]  act_base_r;
  logic [CNT_W-1:0]   act_count_r;
  logic [CNT_W-1:0]   depth_r, depth_nxt;
  logic [CNT_W-1:0]   depth_m1;

  // Transaction registers
  logic [OPC_W-1:0]     op_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 bad_r;
  logic [IDX_W-1:0]     nidx_r;
  logic [REF_BITS-1:0]  cm1_r;

  // Init
  logic [CW-1:0]    n1_r, capleft_r;
  logic [CW-1:0]    n1_raw, n1_clamp, capleft;
  logic [CNT_W-1:0] fill_r;
  logic [IDX_W-1:0] fill_idx;

  // Decode
  logic [PG_W-1:0] pg;
  logic [CW-1:0]   rel;
  logic            dec_bad;
  logic [IDX_W-1:0] dec_idx;

  // Execute
  logic                ref_we, stk_we, load_out;
  logic [IDX_W-1:0]    ref_wa, stk_wa;
  logic [REF_BITS-1:0] ref_wd, cm1, cp1;
  logic [IDX_W-1:0]    stk_wd;
  logic                clone_split;
  logic [STAT_W-1:0]   res_status;
  logic [ADDR_BITS-1:0] res_addr;
  logic                res_copy, res_freed;
  logic [CNT_OUT_W-1:0] res_cnt;

  // Output register
  logic                 out_valid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [ADDR_BITS-1:0] out_addr_r;
  logic                 out_copy_r, out_freed_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic                 out_free;

  function automatic logic [ADDR_BITS-1:0] page_to_addr(input logic [BASE_W-1:0] b,
                                                        input logic [IDX_W-1:0] i);
    logic [SUM_W-1:0] s;
    s = SUM_W'(b) + SUM_W'(i);
    return ADDR_BITS'(s) << PAGE_SHIFT;
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign depth_m1 = depth_r - 1'b1;
  assign fill_idx = fill_r[IDX_W-1:0];

  // Address decode: aligned and inside [act_base, act_base + act_count)
  assign pg      = addr_r[ADDR_BITS-1:PAGE_SHIFT];
  assign rel     = CW'(pg) - CW'(act_base_r);
  assign dec_bad = (addr_r[PAGE_SHIFT-1:0] != '0) || (CW'(pg) < CW'(act_base_r)) ||
                   (rel >= CW'(act_count_r));
  assign dec_idx = rel[IDX_W-1:0];

  // Page count clamp, split over the init_calc and init_start steps
  assign n1_raw   = (CW'(limit_cfg_r) > CW'(base_cfg_r)) ?
                    (CW'(limit_cfg_r) - CW'(base_cfg_r)) : '0;
  assign n1_clamp = (n1_raw > MAXP_CW) ? MAXP_CW : n1_raw;
  assign capleft  = (CW'(base_cfg_r) >= CAP) ? '0 : (CAP - CW'(base_cfg_r));

  assign cm1 = ref_q - 1'b1;
  assign cp1 = ref_q + 1'b1;
  assign clone_split = (op_r == OP_CLONE) && !bad_r && (ref_q > REF_BITS'(1)) &&
                       (depth_r != '0);

  assign st.is_init     = (op_r == OP_INIT);
  assign st.clone_split = clone_split;
  assign st.fill_done   = (fill_r == act_count_r);
  assign st.out_free    = out_free;

  always_comb begin
    ref_we     = 1'b0;
    ref_wa     = idx_r;
    ref_wd     = '0;
    stk_we     = 1'b0;
    stk_wa     = depth_r[IDX_W-1:0];
    stk_wd     = idx_r;
    depth_nxt  = depth_r;
    load_out   = 1'b0;
    res_status = ST_OK;
    res_addr   = '0;
    res_copy   = 1'b0;
    res_freed  = 1'b0;
    res_cnt    = '0;
    if (cmd.fill_step) begin
      ref_we = 1'b1;
      ref_wa = fill_idx;
      ref_wd = '0;
      stk_we = 1'b1;
      stk_wa = fill_idx;
      stk_wd = fill_idx;
    end else if (cmd.init_done) begin
      depth_nxt = act_count_r;
      load_out  = 1'b1;
    end else if (cmd.clone_fin) begin
      ref_we   = 1'b1;
      ref_wa   = idx_r;
      ref_wd   = cm1_r;
      load_out = 1'b1;
      res_addr = page_to_addr(act_base_r, nidx_r);
      res_copy = 1'b1;
      res_cnt  = CNT_OUT_W'(cm1_r);
    end else if (cmd.exec) begin
      unique case (op_r)
        OP_ALLOC: begin
          load_out = 1'b1;
          if (depth_r == '0) begin
            res_status = ST_OOM;
          end else begin
            ref_we    = 1'b1;
            ref_wa    = stk_q;
            ref_wd    = REF_BITS'(1);
            depth_nxt = depth_m1;
            res_addr  = page_to_addr(act_base_r, stk_q);
            res_cnt   = CNT_OUT_W'(1);
          end
        end
        OP_FREE, OP_ADDREF, OP_CLONE: begin
          load_out = !clone_split;
          if (bad_r) begin
            res_status = ST_BADADDR;
          end else if (ref_q == '0) begin
            res_status = ST_NOTALLOC;
          end else if (op_r == OP_FREE) begin
            ref_we  = 1'b1;
            ref_wd  = cm1;
            res_cnt = CNT_OUT_W'(cm1);
            if (cm1 == '0) begin
              res_freed = 1'b1;
              // push dropped on a full stack
              if (depth_r != MAXP) begin
                stk_we    = 1'b1;
                depth_nxt = depth_r + 1'b1;
              end
            end
          end else if (op_r == OP_ADDREF) begin
            if (ref_q == REF_MAX) begin
              res_status = ST_SAT;
              res_cnt    = CNT_OUT_W'(ref_q);
            end else begin
              ref_we  = 1'b1;
              ref_wd  = cp1;
              res_cnt = CNT_OUT_W'(cp1);
            end
          end else if (ref_q == REF_BITS'(1)) begin
            res_addr = page_to_addr(act_base_r, idx_r);
            res_cnt  = CNT_OUT_W'(ref_q);
          end else if (depth_r == '0) begin
            res_status = ST_OOM;
            res_cnt    = CNT_OUT_W'(ref_q);
          end else begin
            // new page gets count 1 now, old count drops in the clone_fin step
            ref_we    = 1'b1;
            ref_wa    = stk_q;
            ref_wd    = REF_BITS'(1);
            depth_nxt = depth_m1;
          end
        end
        default: load_out = 1'b1;
      endcase
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_wa] <= ref_wd;
    end
    if (cmd.decode) begin
      ref_q <= ref_mem[dec_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (cmd.decode) begin
      stk_q <= stk_mem[depth_m1[IDX_W-1:0]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r  <= '0;
      limit_cfg_r <= LIMIT_RST;
      act_base_r  <= '0;
      act_count_r <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_BASE:  base_cfg_r  <= cfg_data[BASE_W-1:0];
          REG_LIMIT: limit_cfg_r <= cfg_data[LIMIT_W-1:0];
          default:   base_cfg_r  <= base_cfg_r;
        endcase
      end
      if (cmd.init_start) begin
        act_base_r  <= base_cfg_r;
        act_count_r <= (n1_r > capleft_r) ? capleft_r[CNT_W-1:0] : n1_r[CNT_W-1:0];
      end
      depth_r <= depth_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_opcode;
      addr_r <= in_page_addr;
    end
    if (cmd.decode) begin
      idx_r <= dec_idx;
      bad_r <= dec_bad;
    end
    if (cmd.init_calc) begin
      n1_r      <= n1_clamp;
      capleft_r <= capleft;
    end
    if (cmd.init_start) begin
      fill_r <= '0;
    end else if (cmd.fill_step) begin
      fill_r <= fill_r + 1'b1;
    end
    if (cmd.exec && clone_split) begin
      nidx_r <= stk_q;
      cm1_r  <= cm1;
    end
    if (load_out) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
      out_copy_r   <= res_copy;
      out_freed_r  <= res_freed;
      out_cnt_r    <= res_cnt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_addr = out_addr_r;
  assign out_copy_needed = out_copy_r;
  assign out_page_freed  = out_freed_r;
  assign out_ref_count   = out_cnt_r;

  // A result must never overwrite one that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("result register loaded while held");

  // The init sweep stops at the active page count
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_step |-> (fill_r < act_count_r))
    else $error("init sweep ran past the active range");

  // Outside init the stack moves by at most one entry per transaction
  a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd.init_done)) |->
      (depth_r == $past(depth_r)) || (depth_r == $past(depth_r) + 1'b1) ||
      (depth_r == $past(depth_r) - 1'b1))
    else $error("free stack depth jumped");

endmodule

/* rtl/refcounted_page_allocator.sv */
// Top level of the reference-counted page allocator.
// Depends on rcpa_pkg, rcpa_ctrl and rcpa_dp.
//
// One operation is in flight at a time: alloc, free, add_ref and clone_check pass from
// acceptance to result through capture, address decode with the count and stack memory
// reads, and read-modify-write commit; a clone_check that hands out a new page adds a
// second commit, as both counts go through the single write port of the count memory.
// Init runs capture, decode, init_calc and init_start, then a sweep clearing one count
// and pushing one free page per cycle. No clearing is needed after reset: until the first
// init no page is active, alloc reports out_of_memory and page operations bad_address.
// base_page and limit_page take effect at the next init. A finished result is held in
// an output register, so a new operation is accepted while the previous one waits.
module refcounted_page_allocator
  import rcpa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int REF_BITS   = REF_BITS_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OPC_W-1:0]     in_opcode,
  input  logic [ADDR_BITS-1:0] in_page_addr,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    out_status,
  output logic [ADDR_BITS-1:0] out_result_addr,
  output logic                 out_copy_needed,
  output logic                 out_page_freed,
  output logic [CNT_OUT_W-1:0] out_ref_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  rcpa_cmd_t  cmd;
  rcpa_stat_t st;

  assign cfg_ready = 1'b1;

  rcpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  rcpa_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .REF_BITS   (REF_BITS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_opcode       (in_opcode),
    .in_page_addr    (in_page_addr),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_result_addr (out_result_addr),
    .out_copy_needed (out_copy_needed),
    .out_page_freed  (out_page_freed),
    .out_ref_count   (out_ref_count)
  );

endmodule
